// ===== src/ubxr_pkg.sv =====
// Package for the UBX frame receive checker: status codes, register indexes,
// configuration and result structures and sizing constants.
// Depends on nothing; every other file of the block uses it by scoped names.
package ubxr_pkg;

   // Default upper bound on the bytes of one frame.
   localparam int MAX_FRAME_BYTES_DEFAULT = 1024;

   // Field widths fixed by the frame format and the registers.
   localparam int BYTE_W   = 8;
   localparam int LENGTH_W = 10;
   localparam int INDEX_W  = 2;

   // Sync bytes and the bytes of framing around the payload.
   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;
   localparam int FRAME_OVERHEAD = 8;

   // Configuration register indexes.
   localparam logic [INDEX_W-1:0] CSR_EXPECTED_CLASS  = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_EXPECTED_ID     = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_EXPECTED_LENGTH = 2'd2;

   // Frame status codes, the first error found in a frame.
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SYNC1    = 3'd1,
      ST_SYNC2    = 3'd2,
      ST_CLASS    = 3'd3,
      ST_ID       = 3'd4,
      ST_LENGTH   = 3'd5,
      ST_CHECKSUM = 3'd6
   } status_type;

   // Register contents seen by the frame tracker.
   typedef struct packed {
      logic [BYTE_W-1:0]   expected_class;
      logic [BYTE_W-1:0]   expected_id;
      logic [LENGTH_W-1:0] expected_length;
   } config_type;

   // One result item.
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              payload_valid;
      logic              frame_last;
      status_type        frame_status;
   } result_type;

endpackage

// ===== src/ubxr_csr.sv =====
// Configuration registers of the UBX frame receive checker.
// Depends on ubxr_pkg for register indexes and the configuration structure.
module ubxr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [ubxr_pkg::INDEX_W-1:0]   csr_index,
   input  logic [ubxr_pkg::LENGTH_W-1:0]  csr_data,
   output ubxr_pkg::config_type           cfg
);

   ubxr_pkg::config_type cfg_ff, cfg_in;

   // Decode the write transaction; an index beyond the list changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ubxr_pkg::CSR_EXPECTED_CLASS:
               cfg_in.expected_class = csr_data[ubxr_pkg::BYTE_W-1:0];
            ubxr_pkg::CSR_EXPECTED_ID:
               cfg_in.expected_id = csr_data[ubxr_pkg::BYTE_W-1:0];
            ubxr_pkg::CSR_EXPECTED_LENGTH:
               cfg_in.expected_length = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Register bank, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/ubxr_track.sv =====
// Frame tracker: byte position, Fletcher-8 sums and first-error record,
// with the result of the byte at its input worked out in one pass.
// Depends on ubxr_pkg for constants, status codes and structures.
module ubxr_track #(
   parameter int MAX_FRAME_BYTES = ubxr_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [ubxr_pkg::BYTE_W-1:0]   rx_byte,
   input  ubxr_pkg::config_type          cfg,
   output ubxr_pkg::result_type          result
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES);
   localparam int LEN_SUM_W = ubxr_pkg::LENGTH_W + 1;
   localparam int CMP_W = ((POS_W > LEN_SUM_W) ? POS_W : LEN_SUM_W) + 2;

   logic [POS_W-1:0]            pos_ff, pos_in;
   logic [ubxr_pkg::BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [ubxr_pkg::BYTE_W-1:0] sum_b_ff, sum_b_in;
   logic [ubxr_pkg::BYTE_W-1:0] length_low_ff, length_low_in;
   logic                        check_a_ff, check_a_in;
   ubxr_pkg::status_type        first_error_ff, first_error_in;

   logic [CMP_W-1:0]            frame_len;
   logic [CMP_W-1:0]            pos_wide;
   logic                        oversize;
   logic                        in_sum;
   logic                        in_payload;
   logic                        at_last;
   logic                        at_check_a;
   logic                        at_check_b;
   logic [15:0]                 declared_length;
   ubxr_pkg::status_type        hit;
   ubxr_pkg::status_type        error_next;
   logic [ubxr_pkg::BYTE_W-1:0] sum_a_next;

   // Frame geometry from the expected length.
   assign frame_len = CMP_W'(cfg.expected_length) + CMP_W'(ubxr_pkg::FRAME_OVERHEAD);
   assign pos_wide  = CMP_W'(pos_ff);
   assign oversize  = frame_len > CMP_W'(MAX_FRAME_BYTES);

   // Regions of the frame for this byte.
   assign in_sum     = (pos_wide >= CMP_W'(2)) && (pos_wide <= frame_len - CMP_W'(3));
   assign in_payload = (pos_wide >= CMP_W'(6)) && (pos_wide <= frame_len - CMP_W'(3));
   assign at_check_a = pos_wide == frame_len - CMP_W'(2);
   assign at_check_b = pos_wide == frame_len - CMP_W'(1);
   assign at_last    = pos_wide >= frame_len - CMP_W'(1);

   assign declared_length = {rx_byte, length_low_ff};
   assign sum_a_next      = sum_a_ff + rx_byte;

   // Error raised by this byte alone, then kept only if none came before.
   always_comb begin
      hit = ubxr_pkg::ST_OK;
      priority if (pos_wide == CMP_W'(0)) begin
         if (rx_byte != ubxr_pkg::SYNC_FIRST) hit = ubxr_pkg::ST_SYNC1;
      end else if (pos_wide == CMP_W'(1)) begin
         if (rx_byte != ubxr_pkg::SYNC_SECOND) hit = ubxr_pkg::ST_SYNC2;
      end else if (pos_wide == CMP_W'(2)) begin
         if (rx_byte != cfg.expected_class) hit = ubxr_pkg::ST_CLASS;
      end else if (pos_wide == CMP_W'(3)) begin
         if (rx_byte != cfg.expected_id) hit = ubxr_pkg::ST_ID;
      end else if (pos_wide == CMP_W'(5)) begin
         if (declared_length != 16'(cfg.expected_length)) hit = ubxr_pkg::ST_LENGTH;
      end else if (at_check_b) begin
         if (!check_a_ff || (rx_byte != sum_b_ff)) hit = ubxr_pkg::ST_CHECKSUM;
      end else begin
         hit = ubxr_pkg::ST_OK;
      end
      error_next = (first_error_ff == ubxr_pkg::ST_OK) ? hit : first_error_ff;
   end

   // Result of this byte and the state it leaves behind.
   always_comb begin
      pos_in         = pos_ff + POS_W'(1);
      sum_a_in       = in_sum ? sum_a_next : sum_a_ff;
      sum_b_in       = in_sum ? (sum_b_ff + sum_a_next) : sum_b_ff;
      length_low_in  = (pos_wide == CMP_W'(4)) ? rx_byte : length_low_ff;
      check_a_in     = at_check_a ? (rx_byte == sum_a_ff) : check_a_ff;
      first_error_in = error_next;

      result.payload_byte  = in_payload ? rx_byte : '0;
      result.payload_valid = in_payload;
      result.frame_last    = at_last;
      result.frame_status  = at_last ? error_next : ubxr_pkg::ST_OK;

      if (oversize) begin
         result.payload_byte  = '0;
         result.payload_valid = 1'b0;
         result.frame_last    = 1'b1;
         result.frame_status  = ubxr_pkg::ST_LENGTH;
      end

      // A frame end, or a frame that cannot fit, returns to the start state.
      if (oversize || at_last) begin
         pos_in         = '0;
         sum_a_in       = '0;
         sum_b_in       = '0;
         length_low_in  = '0;
         check_a_in     = 1'b0;
         first_error_in = ubxr_pkg::ST_OK;
      end
   end

   // Frame state, advanced by each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         sum_a_ff       <= '0;
         sum_b_ff       <= '0;
         length_low_ff  <= '0;
         check_a_ff     <= 1'b0;
         first_error_ff <= ubxr_pkg::ST_OK;
      end else if (accept) begin
         pos_ff         <= pos_in;
         sum_a_ff       <= sum_a_in;
         sum_b_ff       <= sum_b_in;
         length_low_ff  <= length_low_in;
         check_a_ff     <= check_a_in;
         first_error_ff <= first_error_in;
      end
   end

   // The position always stays inside the largest frame.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_wide < CMP_W'(MAX_FRAME_BYTES))
      else $error("byte position beyond the largest frame");

   // A frame end leaves the tracker at the first byte.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && result.frame_last) |=> (pos_ff == '0))
      else $error("tracker did not restart after frame end");

   // Payload bytes never coincide with the last byte.
   a_payload_not_last: assert property (@(posedge clock) disable iff (reset)
      result.payload_valid |-> !result.frame_last)
      else $error("payload byte flagged as frame end");

   // A checksum error is reported at once and never held over.
   a_no_held_checksum: assert property (@(posedge clock) disable iff (reset)
      first_error_ff != ubxr_pkg::ST_CHECKSUM)
      else $error("checksum error held in state");

endmodule

// ===== src/ubxr_out_reg.sv =====
// Result register of the UBX frame receive checker with its valid flag.
// Depends on ubxr_pkg for the result structure.
module ubxr_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ubxr_pkg::result_type result,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output ubxr_pkg::result_type rsp_result
);

   logic                 valid_ff, valid_in;
   ubxr_pkg::result_type data_ff;

   // Valid rises on a load and falls when the transaction is taken.
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = data_ff;

endmodule

// ===== src/ubx_frame_receive_checker.sv =====
// Top level of the UBX frame receive checker.
// Depends on ubxr_pkg, ubxr_csr, ubxr_track and ubxr_out_reg.
//
// Usage:
//   The req_ channel carries received bytes, one per transaction. Every
//   frame is taken as exactly expected_length + 8 bytes: two sync bytes,
//   class, id, a little-endian length, the payload and two checksum bytes.
//   The rsp_ channel returns one result per byte: payload bytes flagged by
//   rsp_payload_valid, and on the last byte rsp_frame_last with the first
//   error found in rsp_frame_status (0 means the frame is good). The csr_
//   channel writes expected_class (0), expected_id (1) and expected_length
//   (2), always ready; the user writes it only while idle (not enforced).
// Latency and throughput:
//   A result appears in the cycle after its byte is accepted. One byte is
//   accepted every cycle while rsp_ready is high; the whole check is one
//   registered pass through the frame tracker into the result register.
// Reset and stalls:
//   Reset clears the registers, the frame state and the result valid.
//   While rsp_ready is low and a result waits, req_ready is low; a byte is
//   taken in the same cycle as the waiting result is taken.
module ubx_frame_receive_checker #(
   parameter int MAX_FRAME_BYTES = ubxr_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ubxr_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ubxr_pkg::BYTE_W-1:0]   rsp_payload_byte,
   output logic                          rsp_payload_valid,
   output logic                          rsp_frame_last,
   output logic [2:0]                    rsp_frame_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ubxr_pkg::INDEX_W-1:0]  csr_index,
   input  logic [ubxr_pkg::LENGTH_W-1:0] csr_data
);

   ubxr_pkg::config_type cfg;
   ubxr_pkg::result_type result;
   ubxr_pkg::result_type rsp_result;
   logic                 accept;

   // A byte is taken when the result register is free or being emptied.
   assign req_ready = !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   ubxr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ubxr_track #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_track (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .cfg     (cfg),
      .result  (result)
   );

   ubxr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   // Unpack the result transaction onto its ports.
   assign rsp_payload_byte  = rsp_result.payload_byte;
   assign rsp_payload_valid = rsp_result.payload_valid;
   assign rsp_frame_last    = rsp_result.frame_last;
   assign rsp_frame_status  = rsp_result.frame_status;

endmodule

// ===== dv/tb_ubx_frame_receive_checker.sv =====
// Self-checking testbench for the UBX frame receive checker: directed frames, error ordering,
// oversized and mid-frame register cases, the longest length, back-pressure and random traffic.
// Depends on ubxr_pkg and ubx_frame_receive_checker; results are checked against a local tracker.
module tb_ubx_frame_receive_checker;

   localparam int FRAME_BYTES_LIMIT = ubxr_pkg::MAX_FRAME_BYTES_DEFAULT;
   localparam logic [ubxr_pkg::INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int LENGTH_REG_MAX = 2 ** ubxr_pkg::LENGTH_W - 1;
   localparam int LONGEST_PAYLOAD = FRAME_BYTES_LIMIT - ubxr_pkg::FRAME_OVERHEAD;
   localparam int LONGEST_PREFIX = 40;
   localparam int SHORT_PAYLOAD_MAX = 24;
   localparam int SETTLE_CYCLES = 3;
   localparam int HOLD_CYCLES = 200;
   localparam int RANDOM_ITEMS = 430;
   localparam int CYCLE_LIMIT = 400000;

   // Ways in which a well-formed frame is broken.
   typedef enum int {
      FAULT_NONE, FAULT_SYNC1, FAULT_SYNC2, FAULT_CLASS, FAULT_ID,
      FAULT_LENGTH, FAULT_CHECK_A, FAULT_CHECK_B, FAULT_PAYLOAD
   } fault_kind_type;

   // Patterns the result receiver follows when it is not holding off.
   typedef enum int {
      READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_MOSTLY
   } ready_pattern_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [ubxr_pkg::BYTE_W-1:0]   req_rx_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [ubxr_pkg::BYTE_W-1:0]   rsp_payload_byte;
   logic                          rsp_payload_valid;
   logic                          rsp_frame_last;
   logic [2:0]                    rsp_frame_status;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [ubxr_pkg::INDEX_W-1:0]  csr_index = '0;
   logic [ubxr_pkg::LENGTH_W-1:0] csr_data = '0;

   // Local copy of the registers and of the frame tracker state.
   ubxr_pkg::config_type         cfg_now = '0;
   int                           trk_pos = 0;
   logic [ubxr_pkg::BYTE_W-1:0]  trk_sum_a = '0;
   logic [ubxr_pkg::BYTE_W-1:0]  trk_sum_b = '0;
   logic [ubxr_pkg::BYTE_W-1:0]  trk_len_low = '0;
   logic                         trk_ck_a_ok = 1'b0;
   ubxr_pkg::status_type         trk_error = ubxr_pkg::ST_OK;

   ubxr_pkg::result_type         awaited_reports[$];
   logic [ubxr_pkg::BYTE_W-1:0]  frame_q[$];

   int                items_sent = 0;
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                burst_left = 0;
   bit                sender_steady = 1'b0;
   int                hold_asked = 0;
   int                hold_served = 0;
   int                hold_left = 0;
   int                pattern_left = 0;
   ready_pattern_type ready_pattern = READY_ALWAYS;

   ubx_frame_receive_checker #(
      .MAX_FRAME_BYTES(FRAME_BYTES_LIMIT)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_status (rsp_frame_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #2 clock = ~clock;

   // Cycle count and run-away guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ubx_frame_receive_checker regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Frame tracker prediction
   // ------------------------------------------------------------------

   function automatic void clear_tracker();
      trk_pos = 0;
      trk_sum_a = '0;
      trk_sum_b = '0;
      trk_len_low = '0;
      trk_ck_a_ok = 1'b0;
      trk_error = ubxr_pkg::ST_OK;
   endfunction

   // Only the first error of a frame is kept.
   function automatic void note_frame_error(ubxr_pkg::status_type code);
      if (trk_error == ubxr_pkg::ST_OK)
         trk_error = code;
   endfunction

   // Advances the tracker by one received byte and returns the report it causes.
   function automatic ubxr_pkg::result_type track_frame_byte(logic [ubxr_pkg::BYTE_W-1:0] b);
      ubxr_pkg::result_type r;
      int                   frame_len;
      int                   pos;
      r = '0;
      frame_len = int'(cfg_now.expected_length) + ubxr_pkg::FRAME_OVERHEAD;

      // No frame fits: every byte closes a frame of its own with a length error.
      if (frame_len > FRAME_BYTES_LIMIT) begin
         clear_tracker();
         r.frame_last = 1'b1;
         r.frame_status = ubxr_pkg::ST_LENGTH;
         return r;
      end

      pos = trk_pos;
      case (pos)
         0: if (b != ubxr_pkg::SYNC_FIRST) note_frame_error(ubxr_pkg::ST_SYNC1);
         1: if (b != ubxr_pkg::SYNC_SECOND) note_frame_error(ubxr_pkg::ST_SYNC2);
         2: if (b != cfg_now.expected_class) note_frame_error(ubxr_pkg::ST_CLASS);
         3: if (b != cfg_now.expected_id) note_frame_error(ubxr_pkg::ST_ID);
         4: trk_len_low = b;
         5: if ({b, trk_len_low} != {6'd0, cfg_now.expected_length})
               note_frame_error(ubxr_pkg::ST_LENGTH);
         default: ;
      endcase

      // Fletcher sum over class, id, length and payload.
      if (pos >= 2 && pos <= frame_len - 3) begin
         trk_sum_a = trk_sum_a + b;
         trk_sum_b = trk_sum_b + trk_sum_a;
      end

      if (pos >= 6 && pos <= frame_len - 3) begin
         r.payload_valid = 1'b1;
         r.payload_byte = b;
      end

      if (pos == frame_len - 2)
         trk_ck_a_ok = (b == trk_sum_a);

      // The last byte, or a byte at or past the end after a length change.
      if (pos >= frame_len - 1) begin
         if (pos == frame_len - 1 && (!trk_ck_a_ok || b != trk_sum_b))
            note_frame_error(ubxr_pkg::ST_CHECKSUM);
         r.frame_last = 1'b1;
         r.frame_status = trk_error;
         clear_tracker();
      end else begin
         trk_pos = pos + 1;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
               what, cycle_count, got, want);
      mismatch_count++;
   endtask

   // Each result transaction is compared with the oldest awaited report.
   always @(posedge clock) begin : check_reports
      ubxr_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_reports.size() == 0) begin
            report_mismatch("result with none awaited", rsp_payload_byte, 0);
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_payload_byte !== want.payload_byte)
               report_mismatch("payload_byte", rsp_payload_byte, want.payload_byte);
            if (rsp_payload_valid !== want.payload_valid)
               report_mismatch("payload_valid", rsp_payload_valid, want.payload_valid);
            if (rsp_frame_last !== want.frame_last)
               report_mismatch("frame_last", rsp_frame_last, want.frame_last);
            if (rsp_frame_status !== want.frame_status)
               report_mismatch("frame_status", rsp_frame_status, want.frame_status);
         end
      end
   end

   // Receiver readiness: long hold-offs on request, otherwise a changing pattern.
   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            ready_pattern = ready_pattern_type'($urandom_range(READY_ALWAYS, READY_MOSTLY));
            pattern_left = $urandom_range(32, 256);
         end
         pattern_left--;
         case (ready_pattern)
            READY_ALWAYS:   rsp_ready <= 1'b1;
            READY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: rsp_ready <= (cycle_count % 4) != 3;
            default:        rsp_ready <= $urandom_range(0, 7) != 0;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Offers one byte, with random gaps between bursts, and records its report.
   task automatic send_byte(input logic [ubxr_pkg::BYTE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = sender_steady ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      awaited_reports.push_back(track_frame_byte(value));
      items_sent++;
   endtask

   // Stops offering and waits until every awaited report has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write transaction; the caller lowers csr_valid afterwards.
   task automatic write_reg(input logic [ubxr_pkg::INDEX_W-1:0] index,
                            input logic [ubxr_pkg::LENGTH_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         ubxr_pkg::CSR_EXPECTED_CLASS:
            cfg_now.expected_class = data[ubxr_pkg::BYTE_W-1:0];
         ubxr_pkg::CSR_EXPECTED_ID:
            cfg_now.expected_id = data[ubxr_pkg::BYTE_W-1:0];
         ubxr_pkg::CSR_EXPECTED_LENGTH:
            cfg_now.expected_length = data;
         default: ;
      endcase
   endtask

   // Writes all three registers once the block is idle; unused upper bits are random.
   task automatic set_checker_config(input logic [ubxr_pkg::BYTE_W-1:0] cls,
                                     input logic [ubxr_pkg::BYTE_W-1:0] id,
                                     input logic [ubxr_pkg::LENGTH_W-1:0] len);
      wait_drained();
      write_reg(ubxr_pkg::CSR_EXPECTED_CLASS, {2'($urandom_range(0, 3)), cls});
      write_reg(ubxr_pkg::CSR_EXPECTED_ID, {2'($urandom_range(0, 3)), id});
      write_reg(ubxr_pkg::CSR_EXPECTED_LENGTH, len);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ubxr_pkg::BYTE_W-1:0] pick_field_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   task automatic reconfigure_random();
      logic [ubxr_pkg::LENGTH_W-1:0] len;
      len = ($urandom_range(0, 19) == 0) ? '0 :
            ubxr_pkg::LENGTH_W'($urandom_range(0, SHORT_PAYLOAD_MAX));
      set_checker_config(pick_field_byte(), pick_field_byte(), len);
   endtask

   // Builds a well-formed frame with a random payload and its Fletcher checksum.
   function automatic void make_frame(logic [ubxr_pkg::BYTE_W-1:0] cls,
                                      logic [ubxr_pkg::BYTE_W-1:0] id,
                                      logic [15:0] len_field, int n_payload);
      logic [ubxr_pkg::BYTE_W-1:0] ck_a;
      logic [ubxr_pkg::BYTE_W-1:0] ck_b;
      frame_q.delete();
      frame_q.push_back(ubxr_pkg::SYNC_FIRST);
      frame_q.push_back(ubxr_pkg::SYNC_SECOND);
      frame_q.push_back(cls);
      frame_q.push_back(id);
      frame_q.push_back(len_field[7:0]);
      frame_q.push_back(len_field[15:8]);
      for (int k = 0; k < n_payload; k++)
         frame_q.push_back(8'($urandom));
      ck_a = '0;
      ck_b = '0;
      for (int k = 2; k < frame_q.size(); k++) begin
         ck_a = ck_a + frame_q[k];
         ck_b = ck_b + ck_a;
      end
      frame_q.push_back(ck_a);
      frame_q.push_back(ck_b);
   endfunction

   function automatic void make_config_frame();
      make_frame(cfg_now.expected_class, cfg_now.expected_id,
                 16'(cfg_now.expected_length), cfg_now.expected_length);
   endfunction

   // Flips bits of the byte that the fault names.
   function automatic void inject_fault(fault_kind_type fault);
      int k;
      case (fault)
         FAULT_SYNC1:   k = 0;
         FAULT_SYNC2:   k = 1;
         FAULT_CLASS:   k = 2;
         FAULT_ID:      k = 3;
         FAULT_LENGTH:  k = $urandom_range(4, 5);
         FAULT_CHECK_A: k = frame_q.size() - 2;
         FAULT_CHECK_B: k = frame_q.size() - 1;
         FAULT_PAYLOAD: k = (frame_q.size() > ubxr_pkg::FRAME_OVERHEAD) ?
                            $urandom_range(6, frame_q.size() - 3) : frame_q.size() - 1;
         default:       k = -1;
      endcase
      if (k >= 0)
         frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
   endfunction

   task automatic send_frame_part(input int first, input int stop);
      for (int k = first; k < stop; k++)
         send_byte(frame_q[k]);
   endtask

   // Random filler until the block is back at the start of a frame.
   task automatic pad_to_frame_start();
      while (trk_pos != 0)
         send_byte(8'($urandom));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Empty frame against the registers as they come out of reset.
   task automatic test_good_frame();
      make_frame(8'h00, 8'h00, 16'd0, 0);
      send_frame_part(0, frame_q.size());
      wait_drained();
   endtask

   // Lengths above the frame limit: every byte is a frame of its own.
   task automatic test_oversized();
      set_checker_config(8'h00, 8'h00, ubxr_pkg::LENGTH_W'(LENGTH_REG_MAX));
      send_byte(8'h00);
      send_byte(8'hFF);
      wait_drained();
      write_reg(CSR_UNUSED_INDEX, ubxr_pkg::LENGTH_W'(LENGTH_REG_MAX));
      write_reg(ubxr_pkg::CSR_EXPECTED_LENGTH, ubxr_pkg::LENGTH_W'(LONGEST_PAYLOAD + 1));
      csr_valid <= 1'b0;
      send_byte(ubxr_pkg::SYNC_FIRST);
      wait_drained();
   endtask

   // The length shrinks while a frame is open: once onto the last position, once past it.
   task automatic test_config_mid_frame();
      set_checker_config(8'hFF, 8'hFF, 10'd4);
      make_frame(8'hFF, 8'hFF, 16'd4, 4);
      send_frame_part(0, 7);
      wait_drained();
      write_reg(ubxr_pkg::CSR_EXPECTED_LENGTH, 10'd0);
      csr_valid <= 1'b0;
      send_byte(frame_q[7]);
      set_checker_config(8'hFF, 8'hFF, 10'd4);
      make_frame(8'hFF, 8'hFF, 16'd4, 4);
      send_frame_part(0, 10);
      wait_drained();
      write_reg(ubxr_pkg::CSR_EXPECTED_LENGTH, 10'd0);
      csr_valid <= 1'b0;
      send_byte(frame_q[10]);
      wait_drained();
   endtask

   // Each fault alone, then several at once so that the first one must win.
   task automatic test_error_order();
      set_checker_config(pick_field_byte(), pick_field_byte(), 10'($urandom_range(1, 6)));
      for (int f = FAULT_SYNC1; f <= FAULT_PAYLOAD; f++) begin
         make_config_frame();
         inject_fault(fault_kind_type'(f));
         send_frame_part(0, frame_q.size());
      end
      repeat (8) begin
         make_config_frame();
         repeat ($urandom_range(2, 3))
            inject_fault(fault_kind_type'($urandom_range(FAULT_SYNC1, FAULT_PAYLOAD)));
         send_frame_part(0, frame_q.size());
      end
      wait_drained();
   endtask

   // The largest length that still fits: the frame opens as a normal frame with payload,
   // then a length change closes it.
   task automatic test_longest_frame();
      set_checker_config(pick_field_byte(), pick_field_byte(),
                         ubxr_pkg::LENGTH_W'(LONGEST_PAYLOAD));
      make_config_frame();
      send_frame_part(0, LONGEST_PREFIX);
      wait_drained();
      write_reg(ubxr_pkg::CSR_EXPECTED_LENGTH, 10'd0);
      csr_valid <= 1'b0;
      send_byte(frame_q[LONGEST_PREFIX]);
      wait_drained();
   endtask

   // The receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_backpressure();
      set_checker_config(pick_field_byte(), pick_field_byte(), 10'd10);
      sender_steady = 1'b1;
      hold_asked++;
      repeat (4) begin
         make_config_frame();
         send_frame_part(0, frame_q.size());
      end
      wait_drained();
      sender_steady = 1'b0;
   endtask

   // Mostly well-formed frames, with faults, noise, length changes and oversized stretches.
   task automatic test_random_traffic();
      int                            stop_at;
      int                            pick;
      int                            cut;
      logic [ubxr_pkg::LENGTH_W-1:0] new_len;
      stop_at = items_sent + RANDOM_ITEMS;
      reconfigure_random();
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 19) == 0)
            sender_steady = !sender_steady;
         if ($urandom_range(0, 99) < 15)
            reconfigure_random();
         pick = $urandom_range(0, 99);
         make_config_frame();
         if (pick < 60) begin
            send_frame_part(0, frame_q.size());
         end else if (pick < 82) begin
            repeat ($urandom_range(1, 3))
               inject_fault(fault_kind_type'($urandom_range(FAULT_SYNC1, FAULT_PAYLOAD)));
            send_frame_part(0, frame_q.size());
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 12))
               send_byte(8'($urandom));
            pad_to_frame_start();
         end else if (pick < 96) begin
            // Part of a frame, then a new length while the frame is still open.
            cut = $urandom_range(1, frame_q.size() - 1);
            send_frame_part(0, cut);
            wait_drained();
            new_len = ($urandom_range(0, 3) == 0) ?
                      ubxr_pkg::LENGTH_W'($urandom_range(LONGEST_PAYLOAD + 1, LENGTH_REG_MAX)) :
                      ubxr_pkg::LENGTH_W'($urandom_range(0, SHORT_PAYLOAD_MAX));
            write_reg(ubxr_pkg::CSR_EXPECTED_LENGTH, new_len);
            csr_valid <= 1'b0;
            send_frame_part(cut, frame_q.size());
            pad_to_frame_start();
            if (new_len > LONGEST_PAYLOAD)
               reconfigure_random();
         end else begin
            wait_drained();
            write_reg(ubxr_pkg::CSR_EXPECTED_LENGTH,
                      ubxr_pkg::LENGTH_W'($urandom_range(LONGEST_PAYLOAD + 1, LENGTH_REG_MAX)));
            csr_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom));
            reconfigure_random();
         end
      end
      wait_drained();
   endtask

   // ------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------

   initial begin
      clear_tracker();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_good_frame();
      test_oversized();
      test_config_mid_frame();
      test_error_order();
      test_longest_frame();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      if (mismatch_count == 0)
         $display("ubx_frame_receive_checker regression: pass");
      else
         $display("ubx_frame_receive_checker regression: fail");
      $finish;
   end

endmodule
